// File: rtl/ppu_pkg.sv
// Shared types and constants for the palette pixel upscaler.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

	localparam int SRC_WIDTH     = 320;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int IDX_W   = 8;
	localparam int CHAN_W  = 8;
	localparam int RGB_W   = 3 * CHAN_W;
	localparam int COL_W   = 9;
	localparam int LINE_W  = 9;
	localparam int PHASE_W = 3;
	localparam int COPY_W  = 2;

	localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE  = 8'hff;
	localparam logic [PHASE_W-1:0] PHASE_RESTART = 3'd5;
	localparam logic [PHASE_W-1:0] PHASE_EXTRA   = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_EXTRA_F = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_AFTER   = 3'd1;
	localparam logic [COPY_W-1:0]  COPIES_BASE   = 2'd2;
	localparam logic [COPY_W-1:0]  COPIES_EXTRA  = 2'd3;

	localparam logic REQ_PAL_WRITE = 1'b0;
	localparam logic REQ_PIXEL     = 1'b1;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;

	localparam int QDEPTH = 4;
	localparam int Q_AW   = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [COPY_W-1:0]  line_copies;
		logic [LINE_W-1:0]  dest_first_line;
		logic [COL_W:0]     dest_column;
		logic               row_done;
		logic               in_range;
	} place_t;

	typedef struct packed {
		logic   valid;
		place_t place;
	} item_t;

	typedef struct packed {
		logic [COPY_W-1:0]     line_copies;
		logic [LINE_W-1:0]     dest_first_line;
		logic [COL_W:0]        dest_column;
		logic [4*CHAN_W-1:0]   argb_pixel;
	} out_word_t;

	typedef struct packed {
		logic      row_done;
		out_word_t word;
	} q_entry_t;

endpackage
`default_nettype wire

// File: rtl/ppu_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppu_front.sv
// Front end: accepts words, classifies them, places pixels, drives the palette port.
`timescale 1ns / 1ps
`default_nettype none
module ppu_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [ppu_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic [ppu_pkg::S_TUSER_W-1:0]    s_tuser,
	input  wire logic                             room,
	output logic                                  ram_we,
	output logic                                  ram_re,
	output logic      [ppu_pkg::PAL_AW-1:0]       ram_addr,
	output logic      [ppu_pkg::RGB_W-1:0]        ram_wdata,
	output ppu_pkg::item_t                        item_s1
);
	import ppu_pkg::*;

	logic [COL_W-1:0]   col_q;
	logic [LINE_W-1:0]  line_q;
	logic [PHASE_W-1:0] phase_q;
	logic               flip_q;

	logic [IDX_W-1:0]   idx;
	logic               is_pixel;
	logic               frame_start;
	logic               accept;
	logic               in_range;
	logic [COL_W-1:0]   col_e;
	logic [LINE_W-1:0]  line_e;
	logic [PHASE_W-1:0] phase_e;
	logic               flip_e;
	logic               extra;
	logic [COPY_W-1:0]  copies;
	logic               last;

	assign s_tready    = room;
	assign accept      = s_tvalid & s_tready;
	assign idx         = s_tdata[IDX_W-1:0];
	assign is_pixel    = (s_tuser[0] == REQ_PIXEL);
	assign frame_start = s_tuser[1];
	assign in_range    = ({1'b0, idx} < (IDX_W + 1)'(PALETTE_DEPTH));

	assign ram_we    = accept & (s_tuser[0] == REQ_PAL_WRITE) & in_range;
	assign ram_re    = accept & is_pixel;
	assign ram_addr  = idx[PAL_AW-1:0];
	assign ram_wdata = {s_tdata[IDX_W +: CHAN_W], s_tdata[IDX_W + CHAN_W +: CHAN_W],
	                    s_tdata[IDX_W + 2*CHAN_W +: CHAN_W]};

	always_comb begin
		col_e   = frame_start ? '0 : col_q;
		line_e  = frame_start ? '0 : line_q;
		phase_e = frame_start ? '0 : phase_q;
		flip_e  = frame_start ? 1'b0 : flip_q;
		extra   = (phase_e == (flip_e ? PHASE_EXTRA_F : PHASE_EXTRA)) ||
		          (phase_e == PHASE_RESTART);
		copies  = extra ? COPIES_EXTRA : COPIES_BASE;
		last    = (col_e >= COL_W'(SRC_WIDTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			line_q  <= '0;
			phase_q <= '0;
			flip_q  <= 1'b0;
		end else if (accept && is_pixel) begin
			if (last) begin
				col_q  <= '0;
				line_q <= line_e + LINE_W'(copies);
				if (phase_e == PHASE_RESTART) begin
					phase_q <= PHASE_AFTER;
					flip_q  <= ~flip_e;
				end else begin
					phase_q <= phase_e + PHASE_W'(1);
					flip_q  <= flip_e;
				end
			end else begin
				col_q   <= col_e + COL_W'(1);
				line_q  <= line_e;
				phase_q <= phase_e;
				flip_q  <= flip_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept & is_pixel;
			if (accept && is_pixel) begin
				item_s1.place.line_copies     <= copies;
				item_s1.place.dest_first_line <= line_e;
				item_s1.place.dest_column     <= {col_e, 1'b0};
				item_s1.place.row_done        <= last;
				item_s1.place.in_range        <= in_range;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ppu_back.sv
// Back end: builds ARGB result words and queues them toward the output.
`timescale 1ns / 1ps
`default_nettype none
module ppu_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  ppu_pkg::item_t                        item_s1,
	input  wire logic [ppu_pkg::RGB_W-1:0]        ram_rdata,
	output logic                                  room,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [ppu_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                                  m_tlast
);
	import ppu_pkg::*;

	localparam int PAD_W = M_TDATA_W - $bits(out_word_t);

	q_entry_t            entry_q [QDEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;
	q_entry_t            push_entry;
	q_entry_t            head;

	assign push = item_s1.valid;
	assign pop  = m_tvalid & m_tready;
	assign room = (({1'b0, count_q} + (QCNT_W + 1)'(item_s1.valid)) <
	              (QCNT_W + 1)'(QDEPTH));

	always_comb begin
		push_entry.row_done             = item_s1.place.row_done;
		push_entry.word.line_copies     = item_s1.place.line_copies;
		push_entry.word.dest_first_line = item_s1.place.dest_first_line;
		push_entry.word.dest_column     = item_s1.place.dest_column;
		push_entry.word.argb_pixel      = {ALPHA_OPAQUE,
		                                   item_s1.place.in_range ? ram_rdata : RGB_W'(0)};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign head     = entry_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {{PAD_W{1'b0}}, head.word};
	assign m_tlast  = head.row_done;

endmodule
`default_nettype wire

// File: rtl/palette_pixel_upscaler.sv
// Top level of the palette pixel upscaler.
`timescale 1ns / 1ps
`default_nettype none
// Takes palette writes and 8-bit indexed source pixels in raster order and returns one opaque
// ARGB8888 word per pixel with its placement: even destination column (pixel doubled
// horizontally), first destination line of its row, and 2 or 3 line copies for that row.
// One word is accepted per clock cycle while the result queue has room; a pixel result passes
// through the registered read of the single palette RAM port and then the four-entry result
// queue before it leaves. The single RAM port takes one write or one read per cycle, which
// sets the rate at one word per cycle. The frame_start flag on a pixel clears the counters.
module palette_pixel_upscaler (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pal_index, red_in, green_in, blue_in
	input  wire logic [ppu_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type, frame_start
	input  wire logic [ppu_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// argb_pixel, dest_column, dest_first_line, line_copies, zero pad
	output logic      [ppu_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                                  m_tlast
);
	import ppu_pkg::*;

	logic               room;
	logic               ram_we;
	logic               ram_re;
	logic [PAL_AW-1:0]  ram_addr;
	logic [RGB_W-1:0]   ram_wdata;
	logic [RGB_W-1:0]   ram_rdata;
	item_t              item_s1;

	ppu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.room      (room),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.item_s1   (item_s1)
	);

	ppu_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	ppu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.ram_rdata (ram_rdata),
		.room      (room),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// File: verif/palette_pixel_upscaler_tb.sv
// Self-checking testbench for the palette pixel upscaler: queued stream stimulus, placement predictor, word checker.
`timescale 1ns / 1ps
module palette_pixel_upscaler_tb;
	import ppu_pkg::*;

	localparam int IDLE_NONE   = 0;
	localparam int IDLE_LIGHT  = 1;
	localparam int IDLE_HEAVY  = 2;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int SWEEP_ROWS  = 2;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        req;
		logic [7:0]  idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        frame_start;
		logic [3:0]  gap;
		logic        drain;
	} src_word_t;

	typedef struct packed {
		logic [31:0] argb;
		logic [9:0]  column;
		logic [8:0]  first_line;
		logic [1:0]  copies;
		logic        row_done;
	} place_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tlast;

	src_word_t   to_send[$];
	place_word_t due_words[$];
	src_word_t   next_word;
	src_word_t   on_bus;
	bit          staged = 1'b0;
	int unsigned gap_left = 0;

	logic [23:0] pal_shadow[256];
	logic [8:0]  col_cnt;
	logic [8:0]  line_base;
	logic [2:0]  phase;
	logic        flip;

	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned rx_count = 0;
	int unsigned err_count = 0;
	place_word_t got_word;
	place_word_t want_word;

	logic [7:0] known_idx[$];

	palette_pixel_upscaler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned idle_draw(int mode);
		if (mode == IDLE_HEAVY)
			return $urandom_range(0, 8);
		if (mode == IDLE_LIGHT)
			return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
		return 0;
	endfunction

	function automatic int rx_mode(int unsigned count);
		case ((count / 250) % 4)
			0: return IDLE_HEAVY;
			1: return IDLE_NONE;
			default: return IDLE_LIGHT;
		endcase
	endfunction

	task automatic upscale_predict(input src_word_t w);
		place_word_t e;
		logic [2:0]  extra_at;
		if (w.req == REQ_PAL_WRITE) begin
			if (int'(w.idx) < PALETTE_DEPTH)
				pal_shadow[w.idx] = {w.red, w.green, w.blue};
		end else begin
			if (w.frame_start) begin
				col_cnt = '0;
				line_base = '0;
				phase = '0;
				flip = 1'b0;
			end
			extra_at = flip ? PHASE_EXTRA_F : PHASE_EXTRA;
			e.copies = (phase == extra_at || phase == PHASE_RESTART) ? COPIES_EXTRA : COPIES_BASE;
			e.argb = (int'(w.idx) < PALETTE_DEPTH) ? {ALPHA_OPAQUE, pal_shadow[w.idx]}
				: {ALPHA_OPAQUE, 24'h0};
			e.column = {col_cnt, 1'b0};
			e.first_line = line_base;
			e.row_done = (int'(col_cnt) >= SRC_WIDTH - 1);
			due_words.push_back(e);
			if (e.row_done) begin
				col_cnt = '0;
				line_base = line_base + 9'(e.copies);
				if (phase == PHASE_RESTART) begin
					phase = '0;
					flip = ~flip;
				end
				phase = phase + 3'd1;
			end else begin
				col_cnt = col_cnt + 9'd1;
			end
		end
	endtask

	// drive source words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			staged = 1'b0;
			gap_left = 0;
			col_cnt = '0;
			line_base = '0;
			phase = '0;
			flip = 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				upscale_predict(on_bus);
			if (!s_tvalid || s_tready) begin
				if (!staged && to_send.size() != 0) begin
					next_word = to_send.pop_front();
					staged = 1'b1;
					gap_left = next_word.gap;
				end
				if (staged && gap_left == 0 && (!next_word.drain || due_words.size() == 0)) begin
					on_bus = next_word;
					staged = 1'b0;
					s_tvalid <= 1'b1;
					s_tdata <= {next_word.blue, next_word.green, next_word.red, next_word.idx};
					s_tuser <= {next_word.frame_start, next_word.req};
				end else begin
					s_tvalid <= 1'b0;
					if (staged && gap_left != 0)
						gap_left = gap_left - 1;
				end
			end
		end
	end

	// accept and check result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
			hold_done = 1'b0;
			rx_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_word.argb = m_tdata[31:0];
				got_word.column = m_tdata[41:32];
				got_word.first_line = m_tdata[50:42];
				got_word.copies = m_tdata[52:51];
				got_word.row_done = m_tlast;
				if (due_words.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected word: argb=%h col=%0d line=%0d copies=%0d last=%b",
							got_word.argb, got_word.column, got_word.first_line,
							got_word.copies, got_word.row_done);
				end else begin
					want_word = due_words.pop_front();
					if (got_word != want_word) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("word %0d mismatch: exp argb=%h col=%0d line=%0d copies=%0d last=%b, got argb=%h col=%0d line=%0d copies=%0d last=%b",
								rx_count, want_word.argb, want_word.column,
								want_word.first_line, want_word.copies, want_word.row_done,
								got_word.argb, got_word.column, got_word.first_line,
								got_word.copies, got_word.row_done);
					end
				end
				rx_count++;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && rx_count == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				rx_wait = idle_draw(rx_mode(rx_count));
				m_tready <= (rx_wait == 0);
			end else if (rx_wait != 0) begin
				rx_wait = rx_wait - 1;
				m_tready <= (rx_wait == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic add_write(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic fs, input int mode);
		src_word_t w;
		w.req = REQ_PAL_WRITE;
		w.idx = idx;
		w.red = r;
		w.green = g;
		w.blue = b;
		w.frame_start = fs;
		w.gap = 4'(idle_draw(mode));
		w.drain = 1'b0;
		to_send.push_back(w);
		known_idx.push_back(idx);
	endtask

	task automatic add_pixel(input logic [7:0] idx, input logic fs, input int mode,
		input logic drain);
		src_word_t w;
		w.req = REQ_PIXEL;
		w.idx = idx;
		w.red = 8'($urandom);
		w.green = 8'($urandom);
		w.blue = 8'($urandom);
		w.frame_start = fs;
		w.gap = 4'(idle_draw(mode));
		w.drain = drain;
		to_send.push_back(w);
	endtask

	function automatic logic [7:0] pick_known();
		return known_idx[$urandom_range(0, known_idx.size() - 1)];
	endfunction

	task automatic add_random_write(input logic fs, input int mode);
		add_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fs, mode);
	endtask

	initial begin : stimulus
		int mode;
		add_write(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, IDLE_NONE);
		add_write(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, IDLE_NONE);
		add_write(8'haa, 8'h12, 8'h34, 8'h56, 1'b1, IDLE_NONE);
		add_write(8'h55, 8'hff, 8'h00, 8'hff, 1'b0, IDLE_NONE);
		add_pixel(8'h00, 1'b1, IDLE_NONE, 1'b0);
		add_pixel(8'hff, 1'b0, IDLE_NONE, 1'b0);
		add_pixel(8'haa, 1'b0, IDLE_NONE, 1'b0);
		add_write(8'h11, 8'h80, 8'h01, 8'h7f, 1'b1, IDLE_NONE);
		add_pixel(8'h55, 1'b0, IDLE_NONE, 1'b0);
		add_write(8'h55, 8'h01, 8'hfe, 8'h80, 1'b0, IDLE_NONE);
		add_pixel(8'h55, 1'b0, IDLE_NONE, 1'b0);
		add_pixel(8'h11, 1'b0, IDLE_HEAVY, 1'b0);
		add_pixel(8'h55, 1'b1, IDLE_HEAVY, 1'b0);
		add_pixel(8'hff, 1'b0, IDLE_NONE, 1'b0);
		add_pixel(8'h00, 1'b1, IDLE_NONE, 1'b1);
		add_pixel(8'haa, 1'b0, IDLE_NONE, 1'b0);

		for (int i = 0; i < 200; i++) begin
			mode = ((i / 50) % 3 == 0) ? IDLE_HEAVY : ((i / 50) % 3 == 1) ? IDLE_NONE : IDLE_LIGHT;
			if ($urandom_range(0, 3) == 0)
				add_random_write(1'($urandom), mode);
			else
				add_pixel(pick_known(), $urandom_range(0, 99) == 0, mode, i == 100);
		end

		for (int row = 0; row < SWEEP_ROWS; row++) begin
			for (int c = 0; c < SRC_WIDTH; c++) begin
				mode = (row < 1) ? IDLE_HEAVY : IDLE_LIGHT;
				if ($urandom_range(0, 31) == 0)
					add_random_write(1'($urandom), mode);
				add_pixel(pick_known(), row == 0 && c == 0, mode, row == 0 && c == 0);
			end
		end
		add_pixel(8'hff, 1'b1, IDLE_HEAVY, 1'b0);
		add_pixel(8'h00, 1'b0, IDLE_NONE, 1'b0);
		add_pixel(pick_known(), 1'b0, IDLE_NONE, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (to_send.size() == 0 && !staged && !s_tvalid);
		wait (due_words.size() == 0);
		repeat (50) @(posedge clk);
		if (err_count == 0 && due_words.size() == 0) begin
			$display("PASS palette_pixel_upscaler");
		end else begin
			$display("FAIL palette_pixel_upscaler");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("FAIL palette_pixel_upscaler");
		$finish;
	end

endmodule
